>>> design/dstk_pkg.sv
package dstk_pkg;

    localparam int DATA_W = 64;

    typedef logic [DATA_W-1:0] word_t;

    localparam logic [4:0] CMD_PUSH  = 5'd0;
    localparam logic [4:0] CMD_DROP  = 5'd1;
    localparam logic [4:0] CMD_DROP2 = 5'd2;
    localparam logic [4:0] CMD_DROP3 = 5'd3;
    localparam logic [4:0] CMD_DUP   = 5'd4;
    localparam logic [4:0] CMD_DUP2  = 5'd5;
    localparam logic [4:0] CMD_DUP3  = 5'd6;
    localparam logic [4:0] CMD_DUPD  = 5'd7;
    localparam logic [4:0] CMD_NIP   = 5'd8;
    localparam logic [4:0] CMD_NIP2  = 5'd9;
    localparam logic [4:0] CMD_OVER  = 5'd10;
    localparam logic [4:0] CMD_PICK  = 5'd11;
    localparam logic [4:0] CMD_ROT   = 5'd12;
    localparam logic [4:0] CMD_NROT  = 5'd13;
    localparam logic [4:0] CMD_SWAP  = 5'd14;
    localparam logic [4:0] CMD_SWAPD = 5'd15;
    localparam logic [4:0] CMD_MUL   = 5'd16;
    localparam logic [4:0] CMD_ADD   = 5'd17;
    localparam logic [4:0] CMD_SUB   = 5'd18;
    localparam logic [4:0] CMD_DIV   = 5'd19;
    localparam logic [4:0] CMD_MOD   = 5'd20;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic go_mul;
        logic go_div;
        logic want_mod;
    } alu_req_t;

    function automatic logic [1:0] need_of(input logic [4:0] cmd);
        logic [1:0] n;
        n = 2'd0;
        case (cmd) inside
            CMD_DROP, CMD_DUP:                                   n = 2'd1;
            CMD_DROP2, CMD_DUP2, CMD_DUPD, CMD_NIP, CMD_OVER,
            CMD_SWAP, [CMD_MUL:CMD_MOD]:                         n = 2'd2;
            CMD_DROP3, CMD_DUP3, CMD_NIP2, CMD_PICK, CMD_ROT,
            CMD_NROT, CMD_SWAPD:                                 n = 2'd3;
            default:                                             n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic signed [2:0] grow_of(input logic [4:0] cmd);
        logic signed [2:0] g;
        g = 3'sd0;
        case (cmd) inside
            CMD_PUSH, CMD_DUP, CMD_DUPD, CMD_OVER, CMD_PICK:     g = 3'sd1;
            CMD_DUP2:                                            g = 3'sd2;
            CMD_DUP3:                                            g = 3'sd3;
            CMD_DROP, CMD_NIP, [CMD_MUL:CMD_MOD]:                g = -3'sd1;
            CMD_DROP2, CMD_NIP2:                                 g = -3'sd2;
            CMD_DROP3:                                           g = -3'sd3;
            default:                                             g = 3'sd0;
        endcase
        return g;
    endfunction

endpackage

>>> design/dstk_mem.sv
module dstk_mem
    import dstk_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  word_t         wdata,
    input  logic [AW-1:0] raddr,
    output word_t         rdata
);

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/dstk_alu.sv
module dstk_alu
    import dstk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    input  word_t    a,
    input  word_t    b,
    output logic     done,
    output word_t    result
);

    logic        mul_act_reg;
    logic [1:0]  mcnt_reg;
    logic        div_act_reg;
    logic [5:0]  dcnt_reg;
    logic        sel_div_reg;
    logic        sel_mod_reg;
    logic        done_reg;
    logic [31:0] ma;
    logic [31:0] mb;
    word_t       prod_reg;
    word_t       acc_reg;
    word_t       rem_reg;
    word_t       quo_reg;
    logic [DATA_W:0] rem_sh;
    logic        fits;

    always_comb
    begin
        case (mcnt_reg)
            2'd1:
            begin
                ma = a[31:0];
                mb = b[63:32];
            end
            2'd2:
            begin
                ma = a[63:32];
                mb = b[31:0];
            end
            default:
            begin
                ma = a[31:0];
                mb = b[31:0];
            end
        endcase
    end

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign fits   = rem_sh >= {1'b0, b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_act_reg <= 1'b0;
            div_act_reg <= 1'b0;
            mcnt_reg    <= '0;
            dcnt_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go_mul)
            begin
                mul_act_reg <= 1'b1;
                mcnt_reg    <= '0;
            end
            else if (mul_act_reg)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    mul_act_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
            if (req.go_div)
            begin
                div_act_reg <= 1'b1;
                dcnt_reg    <= '0;
            end
            else if (div_act_reg)
            begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DATA_W - 1))
                begin
                    div_act_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (req.go_mul || req.go_div)
        begin
            sel_div_reg <= req.go_div;
            sel_mod_reg <= req.want_mod;
        end
        if (mul_act_reg)
        begin
            if (mcnt_reg == 2'd1)
            begin
                acc_reg <= prod_reg;
            end
            else if (mcnt_reg != 2'd0)
            begin
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
        end
        if (req.go_div)
        begin
            rem_reg <= '0;
            quo_reg <= a;
        end
        else if (div_act_reg)
        begin
            if (fits)
            begin
                rem_reg <= DATA_W'(rem_sh - {1'b0, b});
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = !sel_div_reg ? acc_reg : (sel_mod_reg ? rem_reg : quo_reg);

endmodule

>>> design/stack_machine_data_stack.sv
// channel   direction  handshake           fields
// command   in         start && !busy      command, literal_value
// result    out        done (one cycle)    top_value, stack_count, status
//
// A stack command is busy through four reads (three entries through the
// registered read port), one check, up to three writes, one read of the
// new top and the result state; a rejected command writes nothing.
// mul adds a multiply phase (one 32x32 multiplier, three partial products);
// div and mod add a divide phase (restoring divider, one quotient bit per cycle).
// Reset clears the depth and the sequencer; the receiver cannot stall.
module stack_machine_data_stack
    import dstk_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  command,
    input  logic [63:0] literal_value,
    output logic        done,
    output logic [63:0] top_value,
    output logic [6:0]  stack_count,
    output logic [1:0]  status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_ALU    = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_TOPRD  = 7'b0100000,
        S_TOPCAP = 7'b1000000
    } state_t;

    state_t            state_reg;
    logic [DW-1:0]     depth_reg;
    logic [4:0]        cmd_reg;
    word_t             lit_reg;
    word_t             x_reg;
    word_t             y_reg;
    word_t             z_reg;
    word_t             res_reg;
    logic [1:0]        rcnt_reg;
    logic [1:0]        wcnt_reg;
    logic [1:0]        stat_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    word_t             mem_wdata;
    logic [AW-1:0]     mem_raddr;
    word_t             mem_rdata;

    alu_req_t          alu_req;
    logic              alu_done;
    word_t             alu_result;

    logic [1:0]        need;
    logic signed [2:0] grow;
    logic signed [DW:0] dsum;
    logic signed [2:0] w_off [3];
    word_t             w_dat [3];
    logic [1:0]        wn;

    function automatic logic [AW-1:0] addr_at(input logic [DW-1:0] d,
                                              input logic signed [2:0] off);
        logic signed [DW+1:0] s;
        s = $signed({2'b00, d}) + (DW+2)'(off);
        return s[AW-1:0];
    endfunction

    assign need = need_of(cmd_reg);
    assign grow = grow_of(cmd_reg);
    assign dsum = $signed({1'b0, depth_reg}) + (DW+1)'(grow);

    always_comb
    begin
        w_off[0] = 3'sd0;
        w_off[1] = 3'sd0;
        w_off[2] = 3'sd0;
        w_dat[0] = z_reg;
        w_dat[1] = z_reg;
        w_dat[2] = z_reg;
        wn       = 2'd0;
        case (cmd_reg) inside
            CMD_PUSH:
            begin
                w_dat[0] = lit_reg;
                wn = 2'd1;
            end
            CMD_DUP:
            begin
                wn = 2'd1;
            end
            CMD_DUP2:
            begin
                w_dat[0] = y_reg;
                w_off[1] = 3'sd1;
                wn = 2'd2;
            end
            CMD_DUP3:
            begin
                w_dat[0] = x_reg;
                w_off[1] = 3'sd1;
                w_dat[1] = y_reg;
                w_off[2] = 3'sd2;
                wn = 2'd3;
            end
            CMD_DUPD:
            begin
                w_off[0] = -3'sd1;
                w_dat[0] = y_reg;
                wn = 2'd2;
            end
            CMD_NIP:
            begin
                w_off[0] = -3'sd2;
                wn = 2'd1;
            end
            CMD_NIP2:
            begin
                w_off[0] = -3'sd3;
                wn = 2'd1;
            end
            CMD_OVER:
            begin
                w_dat[0] = y_reg;
                wn = 2'd1;
            end
            CMD_PICK:
            begin
                w_dat[0] = x_reg;
                wn = 2'd1;
            end
            CMD_ROT:
            begin
                w_off[0] = -3'sd3;
                w_dat[0] = y_reg;
                w_off[1] = -3'sd2;
                w_off[2] = -3'sd1;
                w_dat[2] = x_reg;
                wn = 2'd3;
            end
            CMD_NROT:
            begin
                w_off[0] = -3'sd3;
                w_off[1] = -3'sd2;
                w_dat[1] = x_reg;
                w_off[2] = -3'sd1;
                w_dat[2] = y_reg;
                wn = 2'd3;
            end
            CMD_SWAP:
            begin
                w_off[0] = -3'sd2;
                w_off[1] = -3'sd1;
                w_dat[1] = y_reg;
                wn = 2'd2;
            end
            CMD_SWAPD:
            begin
                w_off[0] = -3'sd3;
                w_dat[0] = y_reg;
                w_off[1] = -3'sd2;
                w_dat[1] = x_reg;
                wn = 2'd2;
            end
            CMD_MUL, CMD_DIV, CMD_MOD:
            begin
                w_off[0] = -3'sd2;
                w_dat[0] = res_reg;
                wn = 2'd1;
            end
            CMD_ADD:
            begin
                w_off[0] = -3'sd2;
                w_dat[0] = y_reg + z_reg;
                wn = 2'd1;
            end
            CMD_SUB:
            begin
                w_off[0] = -3'sd2;
                w_dat[0] = y_reg - z_reg;
                wn = 2'd1;
            end
            default:
            begin
                wn = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = state_reg == S_WRITE;
        mem_waddr = addr_at(depth_reg, w_off[wcnt_reg]);
        mem_wdata = w_dat[wcnt_reg];
        if (state_reg == S_READ)
        begin
            mem_raddr = addr_at(depth_reg, -$signed({1'b0, rcnt_reg}) - 3'sd1);
        end
        else
        begin
            mem_raddr = addr_at(depth_reg, -3'sd1);
        end
    end

    always_comb
    begin
        alu_req.go_mul   = 1'b0;
        alu_req.go_div   = 1'b0;
        alu_req.want_mod = cmd_reg == CMD_MOD;
        if (state_reg == S_EXEC && depth_reg >= DW'(need)
            && !(grow > 3'sd0 && dsum > STACK_DEPTH))
        begin
            alu_req.go_mul = cmd_reg == CMD_MUL;
            alu_req.go_div = (cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) && z_reg != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            rcnt_reg  <= '0;
            wcnt_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rcnt_reg  <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    rcnt_reg <= rcnt_reg + 2'd1;
                    if (rcnt_reg == 2'd3)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    wcnt_reg <= '0;
                    if (depth_reg < DW'(need)
                        || (grow > 3'sd0 && dsum > STACK_DEPTH)
                        || ((cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) && z_reg == '0))
                    begin
                        state_reg <= S_TOPRD;
                    end
                    else if (cmd_reg inside {CMD_MUL, CMD_DIV, CMD_MOD})
                    begin
                        state_reg <= S_ALU;
                    end
                    else if (wn == 2'd0)
                    begin
                        depth_reg <= dsum[DW-1:0];
                        state_reg <= S_TOPRD;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_ALU:
                begin
                    if (alu_done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    wcnt_reg <= wcnt_reg + 2'd1;
                    if (wcnt_reg == wn - 2'd1)
                    begin
                        depth_reg <= dsum[DW-1:0];
                        state_reg <= S_TOPRD;
                    end
                end
                S_TOPRD:
                begin
                    state_reg <= S_TOPCAP;
                end
                S_TOPCAP:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= command;
            lit_reg <= literal_value;
        end
        if (state_reg == S_READ)
        begin
            case (rcnt_reg)
                2'd1:    z_reg <= mem_rdata;
                2'd2:    y_reg <= mem_rdata;
                2'd3:    x_reg <= mem_rdata;
                default: ;
            endcase
        end
        if (state_reg == S_EXEC)
        begin
            if (depth_reg < DW'(need))
            begin
                stat_reg <= ST_UNDER;
            end
            else if (grow > 3'sd0 && dsum > STACK_DEPTH)
            begin
                stat_reg <= ST_OVER;
            end
            else if ((cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) && z_reg == '0)
            begin
                stat_reg <= ST_DIVZ;
            end
            else
            begin
                stat_reg <= ST_OK;
            end
        end
        if (alu_done)
        begin
            res_reg <= alu_result;
        end
    end

    dstk_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dstk_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (y_reg),
        .b      (z_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign busy        = state_reg != S_IDLE;
    assign done        = state_reg == S_TOPCAP;
    assign top_value   = (depth_reg == '0) ? '0 : mem_rdata;
    assign stack_count = 7'(depth_reg);
    assign status      = stat_reg;

endmodule

>>> design/dstk_chk.sv
module dstk_chk
    import dstk_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [6:0] stack_count,
    input logic [1:0] status
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside an item");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted word not taken up");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block not idle after result");

    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_UNDER |-> stack_count < 7'd3)
        else $error("underflow with deep stack");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) && !$past(done) |-> $stable(stack_count))
        else $error("depth changed while idle");

endmodule

bind stack_machine_data_stack dstk_chk u_dstk_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .stack_count (stack_count),
    .status      (status)
);
